/* src/s5h_pkg.sv */
// shared types, constants and helpers for the socks5 client handshake engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package s5h_pkg;

    // credential bytes carried per field (user name, password)
    localparam int          CRED_BYTES   = 8;
    localparam logic [3:0]  CRED_LEN_MAX = 4'(CRED_BYTES);

    // input operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_RX    = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_TARGET_IS_IPV6 = 3'd0;
    localparam logic [2:0] REG_ADDR_HIGH      = 3'd1;
    localparam logic [2:0] REG_ADDR_LOW       = 3'd2;
    localparam logic [2:0] REG_PORT           = 3'd3;
    localparam logic [2:0] REG_USER_LEN       = 3'd4;
    localparam logic [2:0] REG_PASS_LEN       = 3'd5;
    localparam logic [2:0] REG_USER_BYTES     = 3'd6;
    localparam logic [2:0] REG_PASS_BYTES     = 3'd7;

    // protocol bytes
    localparam logic [7:0] SOCKS_VER       = 8'h05;
    localparam logic [7:0] METHOD_NONE     = 8'h00;
    localparam logic [7:0] METHOD_USERPASS = 8'h02;
    localparam logic [7:0] AUTH_VER        = 8'h01;
    localparam logic [7:0] AUTH_OK         = 8'h00;
    localparam logic [7:0] CMD_CONNECT     = 8'h01;
    localparam logic [7:0] RSV_BYTE        = 8'h00;
    localparam logic [7:0] REP_OK          = 8'h00;
    localparam logic [7:0] ATYP_IPV4       = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN     = 8'h03;
    localparam logic [7:0] ATYP_IPV6       = 8'h04;
    localparam logic [7:0] GREET_ONE       = 8'h01;
    localparam logic [7:0] GREET_TWO       = 8'h02;

    // result burst codes, at most one burst per input item
    localparam logic [2:0] BURST_GREET      = 3'd0;
    localparam logic [2:0] BURST_GREET_AUTH = 3'd1;
    localparam logic [2:0] BURST_AUTH       = 3'd2;
    localparam logic [2:0] BURST_CONN4      = 3'd3;
    localparam logic [2:0] BURST_CONN6      = 3'd4;
    localparam logic [2:0] BURST_DONE       = 3'd5;
    localparam logic [2:0] BURST_FAIL       = 3'd6;

    // burst lengths
    localparam logic [4:0] LEN_GREET      = 5'd3;
    localparam logic [4:0] LEN_GREET_AUTH = 5'd4;
    localparam logic [4:0] LEN_CONN4      = 5'd10;
    localparam logic [4:0] LEN_CONN6      = 5'd22;
    localparam logic [4:0] LEN_SINGLE     = 5'd1;
    localparam logic [4:0] LEN_AUTH_FIXED = 5'd3;

    typedef struct packed {
        logic        ipv6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic [3:0]  user_len;
        logic [3:0]  pass_len;
        logic [63:0] user_bytes;
        logic [63:0] pass_bytes;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [2:0] code;
    } t_burst;

    // saturate a credential length
    function automatic logic [3:0] cred_len(input logic [3:0] len);
        return (len > CRED_LEN_MAX) ? CRED_LEN_MAX : len;
    endfunction

endpackage

/* src/s5h_cfg_regs.sv */
// configuration register file for the socks5 client handshake engine
// depends on s5h_pkg
`timescale 1ns / 1ps

module s5h_cfg_regs import s5h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [2:0]  i_wr_index,
    input  logic [63:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_TARGET_IS_IPV6: r_cfg.ipv6       <= i_wr_data[0];
                REG_ADDR_HIGH:      r_cfg.addr_high  <= i_wr_data;
                REG_ADDR_LOW:       r_cfg.addr_low   <= i_wr_data;
                REG_PORT:           r_cfg.port       <= i_wr_data[15:0];
                REG_USER_LEN:       r_cfg.user_len   <= i_wr_data[3:0];
                REG_PASS_LEN:       r_cfg.pass_len   <= i_wr_data[3:0];
                REG_USER_BYTES:     r_cfg.user_bytes <= i_wr_data;
                REG_PASS_BYTES:     r_cfg.pass_bytes <= i_wr_data;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* src/s5h_parser.sv */
// reply parser and phase tracking; picks the result burst, if any, for each input item
// depends on s5h_pkg
`timescale 1ns / 1ps

module s5h_parser import s5h_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_operation,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_burst     o_burst
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_GREET = 3'd1;
    localparam logic [2:0] PH_AUTH  = 3'd2;
    localparam logic [2:0] PH_CONN  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;
    localparam logic [2:0] PH_FAIL  = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic [8:0] r_count, n_count;
    logic [7:0] r_first, n_first;
    logic [7:0] r_atype, n_atype;
    logic [7:0] r_dlen,  n_dlen;

    logic [9:0] rx_cnt;
    logic [9:0] total;
    logic       awaiting;
    t_burst     burst;

    assign rx_cnt   = {1'b0, r_count} + 10'd1;
    assign awaiting = (r_phase == PH_GREET) || (r_phase == PH_AUTH) || (r_phase == PH_CONN);

    // expected connect reply length from the bound address type
    always_comb begin
        if (r_atype == ATYP_IPV4) begin
            total = 10'd10;
        end else if (r_atype == ATYP_IPV6) begin
            total = 10'd22;
        end else if (r_atype == ATYP_DOMAIN) begin
            total = 10'd7 + {2'b00, r_dlen};
        end else begin
            total = 10'd0;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_first    = r_first;
        n_atype    = r_atype;
        n_dlen     = r_dlen;
        burst      = '0;
        burst.code = BURST_GREET;
        if (i_take) begin
            if (i_operation == OP_START) begin
                n_count     = '0;
                n_first     = '0;
                n_atype     = '0;
                n_dlen      = '0;
                n_phase     = PH_GREET;
                burst.valid = 1'b1;
                burst.code  = (i_cfg.user_len != 4'd0) ? BURST_GREET_AUTH : BURST_GREET;
            end else if (awaiting) begin
                n_count = r_count + 9'd1;
                if (r_count == 9'd0) begin
                    n_first = i_rx_byte;
                end else if (r_phase == PH_GREET) begin
                    burst.valid = 1'b1;
                    priority if (r_first != SOCKS_VER) begin
                        n_phase    = PH_FAIL;
                        burst.code = BURST_FAIL;
                    end else if (i_rx_byte == METHOD_NONE) begin
                        n_phase    = PH_CONN;
                        n_count    = '0;
                        burst.code = i_cfg.ipv6 ? BURST_CONN6 : BURST_CONN4;
                    end else if (i_rx_byte == METHOD_USERPASS && i_cfg.user_len != 4'd0) begin
                        n_phase    = PH_AUTH;
                        n_count    = '0;
                        burst.code = BURST_AUTH;
                    end else begin
                        n_phase    = PH_FAIL;
                        burst.code = BURST_FAIL;
                    end
                end else if (r_phase == PH_AUTH) begin
                    burst.valid = 1'b1;
                    if (r_first != AUTH_VER || i_rx_byte != AUTH_OK) begin
                        n_phase    = PH_FAIL;
                        burst.code = BURST_FAIL;
                    end else begin
                        n_phase    = PH_CONN;
                        n_count    = '0;
                        burst.code = i_cfg.ipv6 ? BURST_CONN6 : BURST_CONN4;
                    end
                end else begin
                    if (r_count == 9'd1 && (r_first != SOCKS_VER || i_rx_byte != REP_OK)) begin
                        n_phase     = PH_FAIL;
                        burst.valid = 1'b1;
                        burst.code  = BURST_FAIL;
                    end else begin
                        if (r_count == 9'd3) begin
                            n_atype = i_rx_byte;
                        end
                        if (r_count == 9'd4) begin
                            n_dlen = i_rx_byte;
                        end
                        // address type and length are settled once six bytes are in
                        if (rx_cnt >= 10'd6) begin
                            if (total == 10'd0) begin
                                n_phase     = PH_FAIL;
                                burst.valid = 1'b1;
                                burst.code  = BURST_FAIL;
                            end else if (rx_cnt >= total) begin
                                n_phase     = PH_DONE;
                                burst.valid = 1'b1;
                                burst.code  = BURST_DONE;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_first <= '0;
            r_atype <= '0;
            r_dlen  <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_first <= n_first;
            r_atype <= n_atype;
            r_dlen  <= n_dlen;
        end
    end

    assign o_burst = burst;

    a_fail_enters_fail_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (burst.valid && burst.code == BURST_FAIL) |=> (r_phase == PH_FAIL))
        else $error("fail result without fail phase");

endmodule

/* src/s5h_emitter.sv */
// request byte sequencer with output register; plays one burst a byte per cycle while the output is not stalled
// depends on s5h_pkg
`timescale 1ns / 1ps

module s5h_emitter import s5h_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_burst     i_load,
    input  t_cfg       i_cfg,
    input  logic       i_out_ready,
    output logic       o_can_load,
    output logic       o_out_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_tx_byte,
    output logic       o_last
);

    logic       r_active;
    logic [2:0] r_code;
    logic [4:0] r_idx;
    logic [4:0] r_len;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_tx;
    logic       r_last;

    logic            step;
    logic            last_step;
    logic [3:0]      user_sat;
    logic [3:0]      pass_sat;
    logic [4:0]      load_len;
    logic [1:0]      kind;
    logic [7:0]      byte_val;
    logic [7:0][7:0] user_arr;
    logic [7:0][7:0] pass_arr;
    logic [15:0][7:0] addr6;
    logic [3:0][7:0] addr4;
    logic [4:0]      off4;
    logic [4:0]      u_off;
    logic [4:0]      p_off;

    assign user_sat  = cred_len(i_cfg.user_len);
    assign pass_sat  = cred_len(i_cfg.pass_len);
    assign user_arr  = i_cfg.user_bytes;
    assign pass_arr  = i_cfg.pass_bytes;
    assign addr6     = {i_cfg.addr_high, i_cfg.addr_low};
    assign addr4     = i_cfg.addr_low[31:0];
    assign off4      = r_idx - 5'd4;
    assign u_off     = r_idx - 5'd2;
    assign p_off     = r_idx - 5'd3 - {1'b0, user_sat};

    assign step       = r_active && (!r_out_valid || i_out_ready);
    assign last_step  = (r_idx == r_len - 5'd1);
    assign o_can_load = !r_active || (step && last_step);

    always_comb begin
        unique case (i_load.code)
            BURST_GREET:      load_len = LEN_GREET;
            BURST_GREET_AUTH: load_len = LEN_GREET_AUTH;
            BURST_AUTH:       load_len = LEN_AUTH_FIXED + {1'b0, user_sat} + {1'b0, pass_sat};
            BURST_CONN4:      load_len = LEN_CONN4;
            BURST_CONN6:      load_len = LEN_CONN6;
            default:          load_len = LEN_SINGLE;
        endcase
    end

    // byte at the current position of the burst
    always_comb begin
        kind     = KIND_BYTE;
        byte_val = 8'h00;
        unique case (r_code)
            BURST_GREET: begin
                if (r_idx == 5'd0)      byte_val = SOCKS_VER;
                else if (r_idx == 5'd1) byte_val = GREET_ONE;
                else                    byte_val = METHOD_NONE;
            end
            BURST_GREET_AUTH: begin
                if (r_idx == 5'd0)      byte_val = SOCKS_VER;
                else if (r_idx == 5'd1) byte_val = GREET_TWO;
                else if (r_idx == 5'd2) byte_val = METHOD_NONE;
                else                    byte_val = METHOD_USERPASS;
            end
            BURST_AUTH: begin
                if (r_idx == 5'd0) begin
                    byte_val = AUTH_VER;
                end else if (r_idx == 5'd1) begin
                    byte_val = {4'h0, user_sat};
                end else if (r_idx < 5'd2 + {1'b0, user_sat}) begin
                    byte_val = user_arr[u_off[2:0]];
                end else if (r_idx == 5'd2 + {1'b0, user_sat}) begin
                    byte_val = {4'h0, pass_sat};
                end else begin
                    byte_val = pass_arr[p_off[2:0]];
                end
            end
            BURST_CONN4, BURST_CONN6: begin
                if (r_idx == 5'd0)              byte_val = SOCKS_VER;
                else if (r_idx == 5'd1)         byte_val = CMD_CONNECT;
                else if (r_idx == 5'd2)         byte_val = RSV_BYTE;
                else if (r_idx == 5'd3)         byte_val = (r_code == BURST_CONN6) ? ATYP_IPV6
                                                                                   : ATYP_IPV4;
                else if (r_idx == r_len - 5'd2) byte_val = i_cfg.port[15:8];
                else if (r_idx == r_len - 5'd1) byte_val = i_cfg.port[7:0];
                else if (r_code == BURST_CONN6) byte_val = addr6[4'd15 - off4[3:0]];
                else                            byte_val = addr4[2'd3 - off4[1:0]];
            end
            BURST_DONE: kind = KIND_DONE;
            default:    kind = KIND_FAIL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load.valid) begin
                r_active <= 1'b1;
            end else if (step && last_step) begin
                r_active <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_code <= i_load.code;
            r_idx  <= '0;
            r_len  <= load_len;
        end else if (step) begin
            r_idx <= r_idx + 5'd1;
        end
        if (step) begin
            r_kind <= kind;
            r_tx   <= byte_val;
            r_last <= last_step;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_tx_byte   = r_tx;
    assign o_last      = r_last;

    a_idx_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx < r_len))
        else $error("burst position past burst length");

endmodule

/* src/socks5_client_handshake.sv */
// top level of the socks5 client handshake engine (greeting, auth, connect)
// depends on s5h_pkg, s5h_cfg_regs, s5h_parser, s5h_emitter
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// in        input      i_in_valid / o_in_ready     i_operation, i_rx_byte
// out       output     o_out_valid / i_out_ready   o_kind, o_tx_byte, o_last
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// an item that causes one result or none: one input per cycle while the output is ready
// an item that causes a request: 3 to 22 request bytes, one per cycle while the output
// does not stall, through the single-byte output register; the input register refills
// while the last byte leaves; first results pass the input, burst and output registers
// synchronous active-low reset clears phase, reply counters, config and all valid flags
// a stalled output holds the burst and, through the input register, the input channel

module socks5_client_handshake import s5h_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_rx_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    // input register
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    logic   consume;
    logic   can_load;
    t_cfg   cfg;
    t_burst burst;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    // the held item moves on once the sequencer can take its burst
    assign consume    = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op   <= i_operation;
            r_in_byte <= i_rx_byte;
        end
    end

    s5h_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // protocol state and reply decoding
    s5h_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (consume),
        .i_operation (r_in_op),
        .i_rx_byte   (r_in_byte),
        .i_cfg       (cfg),
        .o_burst     (burst)
    );

    // request bytes and status results, one per cycle while the output is ready
    s5h_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (burst),
        .i_cfg       (cfg),
        .i_out_ready (i_out_ready),
        .o_can_load  (can_load),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last)
    );

    // done and failed stand alone, so they always close their item
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_BYTE) |-> o_last)
        else $error("status result not marked last");

    a_status_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_BYTE) |-> (o_tx_byte == 8'h00))
        else $error("status result carries a byte");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

/* tb/socks5_client_handshake_test.sv */
// self-checking testbench for the socks5 client handshake engine: directed and random handshakes
// a local predictor tracks phase, reply counters and settings; depends on s5h_pkg and the rtl
`timescale 1ns / 1ps

module socks5_client_handshake_test import s5h_pkg::*; ;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    // leave margin after the last result before settings change or the run ends
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int TIMEOUT_NS    = 4_000_000;

    typedef enum logic [2:0] {
        HS_IDLE, HS_GREET, HS_AUTH, HS_CONN, HS_DONE, HS_FAIL
    } t_hs_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       last;
    } t_hs_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_operation = OP_START;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = REG_TARGET_IS_IPV6;
    logic [63:0] i_cfg_data  = 64'd0;

    socks5_client_handshake dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state, mirrors the engine
    t_hs_result  expected_results[$];
    t_cfg        shadow_cfg = '0;
    t_hs_phase   hs_phase   = HS_IDLE;
    logic [8:0]  rx_count   = '0;
    logic [7:0]  rx_first   = '0;
    logic [7:0]  rx_atyp    = '0;
    logic [7:0]  rx_dom_len = '0;
    int          burst_len;

    int          errors     = 0;
    int          busy_items = 0;
    int unsigned in_idle_pct  = 0;
    int unsigned out_idle_pct = 0;
    logic        hold_go      = 1'b0;

    // ---------------------------------------------------------------- predictor

    function automatic void expect_result(logic [1:0] kind, logic [7:0] b);
        t_hs_result r;
        r.kind    = kind;
        r.tx_byte = b;
        r.last    = 1'b0;
        expected_results.push_back(r);
        burst_len++;
    endfunction

    function automatic void expect_byte(logic [7:0] b);
        expect_result(KIND_BYTE, b);
    endfunction

    function automatic void expect_fail();
        hs_phase = HS_FAIL;
        expect_result(KIND_FAIL, 8'h00);
    endfunction

    // length byte then the credential, first character from the low byte
    function automatic void expect_credential(logic [3:0] len, logic [63:0] chars);
        int n;
        n = (len > CRED_BYTES) ? CRED_BYTES : int'(len);
        expect_byte(8'(n));
        for (int i = 0; i < n; i++)
            expect_byte(chars[8*i +: 8]);
    endfunction

    function automatic void expect_connect();
        expect_byte(SOCKS_VER);
        expect_byte(CMD_CONNECT);
        expect_byte(RSV_BYTE);
        if (shadow_cfg.ipv6) begin
            expect_byte(ATYP_IPV6);
            for (int i = 7; i >= 0; i--)
                expect_byte(shadow_cfg.addr_high[8*i +: 8]);
            for (int i = 7; i >= 0; i--)
                expect_byte(shadow_cfg.addr_low[8*i +: 8]);
        end else begin
            expect_byte(ATYP_IPV4);
            for (int i = 3; i >= 0; i--)
                expect_byte(shadow_cfg.addr_low[8*i +: 8]);
        end
        expect_byte(shadow_cfg.port[15:8]);
        expect_byte(shadow_cfg.port[7:0]);
        hs_phase = HS_CONN;
        rx_count = '0;
    endfunction

    // queues the results of one accepted request; returns 0 when the engine ignores it
    function automatic bit predict_request(logic op, logic [7:0] b);
        logic [8:0] idx;
        int         cnt;
        int         total;
        t_hs_result tail;
        bit         taken;
        burst_len = 0;
        taken     = 1'b1;
        if (op == OP_START) begin
            rx_count   = '0;
            rx_first   = '0;
            rx_atyp    = '0;
            rx_dom_len = '0;
            expect_byte(SOCKS_VER);
            if (shadow_cfg.user_len != 0) begin
                expect_byte(GREET_TWO);
                expect_byte(METHOD_NONE);
                expect_byte(METHOD_USERPASS);
            end else begin
                expect_byte(GREET_ONE);
                expect_byte(METHOD_NONE);
            end
            hs_phase = HS_GREET;
        end else if (hs_phase == HS_GREET || hs_phase == HS_AUTH || hs_phase == HS_CONN) begin
            idx      = rx_count;
            rx_count = rx_count + 9'd1;
            if (idx == 0) begin
                rx_first = b;
            end else if (hs_phase == HS_GREET) begin
                if (rx_first != SOCKS_VER)
                    expect_fail();
                else if (b == METHOD_NONE)
                    expect_connect();
                else if (b == METHOD_USERPASS && shadow_cfg.user_len != 0) begin
                    expect_byte(AUTH_VER);
                    expect_credential(shadow_cfg.user_len, shadow_cfg.user_bytes);
                    expect_credential(shadow_cfg.pass_len, shadow_cfg.pass_bytes);
                    hs_phase = HS_AUTH;
                    rx_count = '0;
                end else
                    expect_fail();
            end else if (hs_phase == HS_AUTH) begin
                if (rx_first != AUTH_VER || b != AUTH_OK)
                    expect_fail();
                else
                    expect_connect();
            end else begin
                cnt = int'(idx) + 1;
                // version and status are judged on the second reply byte
                if (idx == 1 && (rx_first != SOCKS_VER || b != REP_OK)) begin
                    expect_fail();
                end else begin
                    if (idx == 3)
                        rx_atyp = b;
                    if (idx == 4)
                        rx_dom_len = b;
                    if (cnt >= 6) begin
                        case (rx_atyp)
                            ATYP_IPV4:   total = 10;
                            ATYP_IPV6:   total = 22;
                            ATYP_DOMAIN: total = 7 + int'(rx_dom_len);
                            default:     total = 0;
                        endcase
                        if (total == 0)
                            expect_fail();
                        else if (cnt >= total) begin
                            hs_phase = HS_DONE;
                            expect_result(KIND_DONE, 8'h00);
                        end
                    end
                end
            end
        end else begin
            taken = 1'b0;
        end
        if (burst_len > 0) begin
            tail      = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.push_back(tail);
        end
        return taken;
    endfunction

    function automatic void apply_reg(logic [2:0] index, logic [63:0] data);
        case (index)
            REG_TARGET_IS_IPV6: shadow_cfg.ipv6       = data[0];
            REG_ADDR_HIGH:      shadow_cfg.addr_high  = data;
            REG_ADDR_LOW:       shadow_cfg.addr_low   = data;
            REG_PORT:           shadow_cfg.port       = data[15:0];
            REG_USER_LEN:       shadow_cfg.user_len   = data[3:0];
            REG_PASS_LEN:       shadow_cfg.pass_len   = data[3:0];
            REG_USER_BYTES:     shadow_cfg.user_bytes = data;
            REG_PASS_BYTES:     shadow_cfg.pass_bytes = data;
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- result side

    // receiver: random stalls, plus one long hold-off started by a rise of hold_go
    logic hold_go_q = 1'b0;
    int   hold_left = 0;

    always @(negedge i_clk) begin
        if (hold_go && !hold_go_q)
            hold_left = HOLD_CYCLES;
        hold_go_q = hold_go;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_hs_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d tx_byte %02h last %0d",
                       o_kind, o_tx_byte, o_last);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    errors++;
                end
                if (o_tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %02h, got %02h", want.tx_byte, o_tx_byte);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // offers one request; returns at the next falling edge with valid still high
    task automatic send_request(input logic op, input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_rx_byte   <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (predict_request(op, b))
            busy_items++;
        @(negedge i_clk);
    endtask

    task automatic start_hs();
        send_request(OP_START, 8'($urandom));
    endtask

    task automatic rx(input logic [7:0] b);
        send_request(OP_RX, b);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        hold_go    <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        apply_reg(index, data);
        @(negedge i_clk);
    endtask

    // narrow registers get random upper bits, which the engine must drop
    task automatic write_settings(input t_cfg c);
        logic [63:0] noise;
        noise = {$urandom, $urandom};
        write_reg(REG_TARGET_IS_IPV6, {noise[63:1], c.ipv6});
        write_reg(REG_ADDR_HIGH, c.addr_high);
        write_reg(REG_ADDR_LOW, c.addr_low);
        write_reg(REG_PORT, {noise[63:16], c.port});
        write_reg(REG_USER_LEN, {noise[59:0], c.user_len});
        write_reg(REG_PASS_LEN, {noise[63:4], c.pass_len});
        write_reg(REG_USER_BYTES, c.user_bytes);
        write_reg(REG_PASS_BYTES, c.pass_bytes);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cfg random_settings();
        t_cfg c;
        c.ipv6       = 1'($urandom_range(1));
        c.addr_high  = {$urandom, $urandom};
        c.addr_low   = {$urandom, $urandom};
        c.port       = 16'($urandom);
        c.user_len   = 4'($urandom_range(15));
        c.pass_len   = 4'($urandom_range(15));
        c.user_bytes = {$urandom, $urandom};
        c.pass_bytes = {$urandom, $urandom};
        return c;
    endfunction

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        in_idle_pct = send_pct;
        out_idle_pct <= recv_pct;
    endtask

    // one handshake, mostly well formed: corrupt bytes, early cut, leading and trailing noise
    task automatic random_handshake();
        logic [7:0] reply[$];
        logic [7:0] atyp;
        bit         use_auth;
        int         dom;
        int         cut;
        if ($urandom_range(7) == 0)
            rx(8'($urandom));
        use_auth = (shadow_cfg.user_len != 0) && ($urandom_range(3) != 0);
        reply.push_back(SOCKS_VER);
        reply.push_back(use_auth ? METHOD_USERPASS : METHOD_NONE);
        if (use_auth) begin
            reply.push_back(AUTH_VER);
            reply.push_back(AUTH_OK);
        end
        reply.push_back(SOCKS_VER);
        reply.push_back(REP_OK);
        reply.push_back(RSV_BYTE);
        case ($urandom_range(9))
            0, 1, 2: atyp = ATYP_IPV4;
            3, 4, 5: atyp = ATYP_IPV6;
            6, 7, 8: atyp = ATYP_DOMAIN;
            default: atyp = 8'($urandom);
        endcase
        reply.push_back(atyp);
        if (atyp == ATYP_IPV6)
            repeat (16) reply.push_back(8'($urandom));
        else if (atyp == ATYP_DOMAIN) begin
            dom = $urandom_range(24);
            reply.push_back(8'(dom));
            repeat (dom) reply.push_back(8'($urandom));
        end else
            repeat (4) reply.push_back(8'($urandom));
        repeat (2) reply.push_back(8'($urandom));
        foreach (reply[i])
            if ($urandom_range(99) < 3)
                reply[i] = 8'($urandom);
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(reply.size() - 1);
            while (reply.size() > cut)
                void'(reply.pop_back());
        end
        start_hs();
        foreach (reply[i])
            rx(reply[i]);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) rx(8'($urandom));
    endtask

    // ---------------------------------------------------------------- tests

    // reset settings: no auth, ipv4 0.0.0.0 port 0
    task automatic test_plain_connect();
        rx(8'hFF);                  // idle, ignored
        start_hs();
        rx(SOCKS_VER);
        rx(METHOD_NONE);            // connect request
        rx(SOCKS_VER);
        rx(REP_OK);
        rx(RSV_BYTE);
        rx(ATYP_DOMAIN);
        rx(8'h00);                  // empty domain name
        rx(8'hAA);
        rx(8'h55);                  // done after seven bytes
        rx(8'h00);                  // after done, ignored
        wait_idle();
    endtask

    task automatic test_greeting_failures();
        start_hs();
        rx(8'h04);
        rx(METHOD_NONE);            // bad version
        rx(8'hFF);                  // after fail, ignored
        start_hs();
        rx(SOCKS_VER);
        rx(8'hFF);                  // unknown method
        start_hs();
        rx(SOCKS_VER);
        rx(METHOD_USERPASS);        // no user name offered
        wait_idle();
    endtask

    // all-ones settings: ipv6, saturated credentials
    task automatic test_auth_ipv6();
        t_cfg c;
        c = '1;
        write_settings(c);
        start_hs();
        rx(SOCKS_VER);
        start_hs();                 // restart in the middle of the greeting reply
        rx(SOCKS_VER);
        rx(METHOD_USERPASS);        // auth request
        rx(AUTH_VER);
        rx(AUTH_OK);                // connect request, longest burst
        rx(SOCKS_VER);
        rx(8'h01);                  // bad status
        start_hs();
        rx(SOCKS_VER);
        rx(METHOD_USERPASS);
        rx(8'h02);
        rx(AUTH_OK);                // bad auth version
        wait_idle();
    endtask

    task automatic test_bad_address_type();
        start_hs();
        rx(SOCKS_VER);
        rx(METHOD_NONE);
        rx(SOCKS_VER);
        rx(REP_OK);
        rx(RSV_BYTE);
        rx(8'h07);
        rx(8'h00);
        rx(8'h00);                  // fails on the sixth byte
        wait_idle();
    endtask

    task automatic test_random_handshakes(input int goal);
        int first;
        t_cfg c;
        c = '0;
        c.user_len = 4'(CRED_BYTES);
        c.pass_len = 4'(CRED_BYTES);
        write_settings(($urandom_range(1) != 0) ? c : random_settings());
        first = busy_items;
        while (busy_items - first < goal / 2)
            random_handshake();
        wait_idle();
        write_settings(random_settings());
        while (busy_items - first < goal)
            random_handshake();
        wait_idle();
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_output_backpressure();
        t_cfg c;
        c = random_settings();
        c.ipv6     = 1'b1;
        c.user_len = 4'hF;
        write_settings(c);
        hold_go <= 1'b1;
        start_hs();
        rx(SOCKS_VER);
        rx(METHOD_USERPASS);
        rx(AUTH_VER);
        rx(AUTH_OK);
        repeat (3) random_handshake();
        wait_idle();
    endtask

    initial begin : run
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        set_idling(14, 88);
        test_plain_connect();
        test_greeting_failures();
        test_auth_ipv6();
        test_bad_address_type();
        test_random_handshakes(40);

        set_idling(88, 14);
        test_random_handshakes(40);

        set_idling(0, 0);
        test_output_backpressure();
        test_random_handshakes(40);

        wait_idle();
        if (errors == 0)
            $display("socks5_client_handshake_test: done, clean");
        else
            $display("socks5_client_handshake_test: done, errors");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $error("timeout with %0d results outstanding", expected_results.size());
        $display("socks5_client_handshake_test: done, errors");
        $finish;
    end

endmodule
